[hdl/gbb_pkg.sv]
// Shared types, constants and helper functions for the grey box-blur unit.
// No dependencies; imported by the line store, the result queue and the top level.
package gbb_pkg;

   // Default line length of the line stores
   localparam int MAX_WIDTH_DEFAULT = 2048;

   // Field widths
   localparam int PIX_W     = 8;
   localparam int REG_W     = 12;
   localparam int ROW_W     = 12;
   localparam int OUT_COL_W = 11;
   localparam int COLSUM_W  = 10;   // three greys
   localparam int SUM_W     = 12;   // nine greys

   // Configuration register indexes
   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [REG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [REG_W-1:0] HEIGHT_RESET = 12'd480;
   localparam int               DIM_MIN      = 3;

   // Luma weights, scaled by 1024
   localparam logic [17:0] GREY_R = 18'd307;
   localparam logic [17:0] GREY_G = 18'd604;
   localparam logic [17:0] GREY_B = 18'd113;

   // Divide by nine as multiply by ceil(2^15 / 9) then shift; exact for sums up to 2295
   localparam logic [23:0] DIV9_RECIP = 24'd3641;
   localparam int          DIV9_SHIFT = 15;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   // Per-pixel bookkeeping carried down the pipeline
   typedef struct packed {
      logic                 emit;
      logic                 frame_last;
      logic [OUT_COL_W-1:0] out_col;
      logic [ROW_W-1:0]     out_row;
   } meta_type;

   // One finished result
   typedef struct packed {
      logic                 frame_last;
      logic [OUT_COL_W-1:0] out_col;
      logic [ROW_W-1:0]     out_row;
      logic [PIX_W-1:0]     blurred;
   } result_type;

   // RGB to grey, weights summing to 1024
   function automatic logic [PIX_W-1:0] grey_of(input logic [PIX_W-1:0] red,
                                                input logic [PIX_W-1:0] green,
                                                input logic [PIX_W-1:0] blue);
      logic [17:0] acc;
      acc = GREY_R * 18'(red) + GREY_G * 18'(green) + GREY_B * 18'(blue);
      return acc[17:10];
   endfunction

endpackage

[hdl/gbb_line_store.sv]
// Two line stores holding the greys of the previous two rows, by column.
// Depends on gbb_pkg. Registered read; a commit shifts the row down one store.
module gbb_line_store import gbb_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   parameter int AW        = $clog2(MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [PIX_W-1:0] wr_grey,
   output logic [PIX_W-1:0] rd_mid,
   output logic [PIX_W-1:0] rd_top
);

   logic [PIX_W-1:0] line_a_mem [MAX_WIDTH];   // previous row
   logic [PIX_W-1:0] line_b_mem [MAX_WIDTH];   // row before that
   logic [PIX_W-1:0] rd_mid_ff;
   logic [PIX_W-1:0] rd_top_ff;

   // read on request accept
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mid_ff <= line_a_mem[rd_addr];
         rd_top_ff <= line_b_mem[rd_addr];
      end
   end

   // commit: new grey into store A, old A value moves to store B
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_a_mem[wr_addr] <= wr_grey;
         line_b_mem[wr_addr] <= rd_mid_ff;
      end
   end

   assign rd_mid = rd_mid_ff;
   assign rd_top = rd_top_ff;

endmodule

[hdl/gbb_rsp_fifo.sv]
// Small result queue between the blur pipeline and the result channel.
// Depends on gbb_pkg (result_type, depth constants).
module gbb_rsp_fifo import gbb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  result_type           push_data,
   input  logic                 pop,
   output logic                 head_valid,
   output result_type           head_data,
   output logic [RSP_CNT_W-1:0] count
);

   result_type             entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   do_pop;

   assign do_pop = pop && (count_ff != '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

[hdl/grey_box_blur_3x3_unit.sv]
// Top level of the grey 3x3 box-blur unit.
// Depends on gbb_pkg, gbb_line_store and gbb_rsp_fifo.
//
// Usage:
//   req_* carries RGB pixels in raster order, one request per pixel.
//   rsp_* carries one blurred grey pixel per interior window centre, with its
//   vertically flipped row and its column; rsp_tlast marks the frame's last one.
//   Border pixels produce no response.
//   csr_* sets image width and height; a write restarts the frame at row 0,
//   column 0. Write only while no request is in flight.
// Path: the request that completes a window reaches rsp_tvalid through the input
//   register, the window stage and the divide into the result queue.
// Throughput: one request per cycle unless the result queue backs up; each pixel
//   takes one line-store read and one line-store write, on separate ports.
// Reset clears the counters, window and result queue and loads width 640 and
//   height 480; line store contents are undefined until the first two rows fill.
// When rsp_tready is held low the four-entry result queue fills and req_tready
//   drops once queued plus in-flight pixels reach four; nothing is lost.
module grey_box_blur_3x3_unit import gbb_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,    // red[7:0], green[15:8], blue[23:16]
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,    // blurred[7:0], out_row[19:8], out_col[30:20], 0
   output logic             rsp_tlast,    // frame_last
   // configuration
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [REG_W-1:0] csr_wdata
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WCMP = (CW + 1 > REG_W) ? CW + 1 : REG_W;

   // configuration and position
   logic [REG_W-1:0] width_ff, width_in;
   logic [REG_W-1:0] height_ff, height_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [WCMP-1:0]  w_ext, w_eff, col_inc;
   logic [ROW_W-1:0] h_eff;
   logic [ROW_W:0]   row_inc;
   logic             col_wrap, row_wrap, req_accept;

   // pipeline
   logic                 p1_valid_ff;
   logic [PIX_W-1:0]     p1_grey_ff;
   logic [CW-1:0]        p1_col_ff;
   meta_type             p1_meta_ff, meta_in;
   logic                 p2_valid_ff;
   logic [SUM_W-1:0]     p2_total_ff, total_in;
   meta_type             p2_meta_ff;
   logic [COLSUM_W-1:0]  cs_new1_ff, cs_new2_ff, colsum_in;

   logic [PIX_W-1:0]     rd_mid, rd_top;
   logic [23:0]          quot_prod;
   result_type           push_data, head_data;
   logic                 push, head_valid;
   logic [RSP_CNT_W-1:0] q_count, occupancy;

   // effective image size
   always_comb begin
      w_ext = WCMP'(width_ff);
      if (w_ext < WCMP'(DIM_MIN)) begin
         w_eff = WCMP'(DIM_MIN);
      end else if (w_ext > WCMP'(MAX_WIDTH)) begin
         w_eff = WCMP'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      h_eff = (height_ff < ROW_W'(DIM_MIN)) ? ROW_W'(DIM_MIN) : height_ff;
   end

   // position advance
   always_comb begin
      col_inc  = WCMP'(col_ff) + 1'b1;
      col_wrap = (col_inc >= w_eff);
      row_inc  = {1'b0, row_ff} + 1'b1;
      row_wrap = (row_inc >= {1'b0, h_eff});
   end

   assign occupancy  = q_count + RSP_CNT_W'(p1_valid_ff) + RSP_CNT_W'(p2_valid_ff);
   assign req_tready = (occupancy < RSP_CNT_W'(RSP_DEPTH));
   assign req_accept = req_tvalid && req_tready;

   // configuration writes and counters
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wdata;
            REG_IMAGE_HEIGHT: height_in = csr_wdata;
            default:          width_in  = width_ff;
         endcase
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // bookkeeping for the window centre this pixel completes
   always_comb begin
      meta_in.emit       = (row_ff >= ROW_W'(2)) && (col_ff >= CW'(2));
      meta_in.frame_last = row_wrap && col_wrap;
      meta_in.out_col    = OUT_COL_W'(col_ff - CW'(1));
      meta_in.out_row    = h_eff - row_ff;
   end

   // input register stage
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_grey_ff <= grey_of(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
         p1_col_ff  <= col_ff;
         p1_meta_ff <= meta_in;
      end
   end

   gbb_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (CW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .wr_en   (p1_valid_ff),
      .wr_addr (p1_col_ff),
      .wr_grey (p1_grey_ff),
      .rd_mid  (rd_mid),
      .rd_top  (rd_top)
   );

   // window stage: column sums shift in, total of three columns
   always_comb begin
      colsum_in = COLSUM_W'(rd_top) + COLSUM_W'(rd_mid) + COLSUM_W'(p1_grey_ff);
      total_in  = SUM_W'(colsum_in) + SUM_W'(cs_new1_ff) + SUM_W'(cs_new2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
         cs_new1_ff  <= '0;
         cs_new2_ff  <= '0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
         if (p1_valid_ff) begin
            cs_new1_ff <= colsum_in;
            cs_new2_ff <= cs_new1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p1_valid_ff) begin
         p2_total_ff <= total_in;
         p2_meta_ff  <= p1_meta_ff;
      end
   end

   // mean of nine into the result queue
   always_comb begin
      quot_prod            = 24'(p2_total_ff) * DIV9_RECIP;
      push                 = p2_valid_ff && p2_meta_ff.emit;
      push_data.blurred    = quot_prod[DIV9_SHIFT +: PIX_W];
      push_data.out_row    = p2_meta_ff.out_row;
      push_data.out_col    = p2_meta_ff.out_col;
      push_data.frame_last = p2_meta_ff.frame_last;
   end

   gbb_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (rsp_tready),
      .head_valid (head_valid),
      .head_data  (head_data),
      .count      (q_count)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = {1'b0, head_data.out_col, head_data.out_row, head_data.blurred};
   assign rsp_tlast  = head_data.frame_last;

endmodule

[hdl/gbb_checker.sv]
// Port-level checks for the grey box-blur unit, bound to the top level.
// Needs no package; watches the handshake and response ports only.
module gbb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [31:0]      rsp_tdata,
   input logic             rsp_tlast
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response withdrawn while stalled");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response payload changed while stalled");

   // reset empties the result queue
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response offered straight after reset");

   // reset empties the pipeline, so requests are taken at once
   a_req_ready_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request channel not ready after reset");

endmodule

bind grey_box_blur_3x3_unit gbb_checker u_gbb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
